// File: rtl/dwr_pkg.sv
`timescale 1ns / 1ps

package dwr_pkg;

  // table and state sizing
  localparam int MAX_EDGES   = 64;
  localparam int STATE_BITS  = 8;
  localparam int STATE_COUNT = 1 << STATE_BITS;
  localparam int EDGE_AW     = $clog2(MAX_EDGES);
  localparam int EDGE_CW     = $clog2(MAX_EDGES + 1);

  // opcodes
  localparam logic [2:0] OP_ADD_EDGE   = 3'd0;
  localparam logic [2:0] OP_ADD_ENTRY  = 3'd1;
  localparam logic [2:0] OP_ADD_ACCEPT = 3'd2;
  localparam logic [2:0] OP_SYMBOL     = 3'd3;
  localparam logic [2:0] OP_END        = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_ENTRY = 2'd3;

  typedef logic [STATE_BITS-1:0] state_t;

  // one stored transition
  typedef struct packed {
    state_t     src;
    logic [7:0] lab;
    state_t     tgt;
  } edge_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dwr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dwr_stat_t;

endpackage

// File: rtl/dfa_word_recognizer_core.sv
`timescale 1ns / 1ps

// channel  direction  handshake           fields
// in       input      in_valid/in_stall   opcode, state_a, symbol, state_b
// out      output     out_valid/out_stall status, word_done, accepted, current_state
//
// one result word per input word; one word is worked on at a time
// a scan reads the transition table through its single read port, one entry a cycle;
// it stops at the first matching entry or after the last stored entry
// words with no scan go from idle straight to the finish state, which registers the result
// rst is synchronous; the table needs no clearing, the accept map clears at once
// a held result stalls only the finish of the following word

module dfa_word_recognizer_core import dwr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [7:0] state_a,
  input  logic [7:0] symbol,
  input  logic [7:0] state_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic       word_done,
  output logic       accepted,
  output logic [7:0] current_state
);

  dwr_cmd_t  cmd;
  dwr_stat_t stat;

  // sequencing
  dwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table, automaton state and result register
  dwr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .state_a       (state_a),
    .symbol        (symbol),
    .state_b       (state_b),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .word_done     (word_done),
    .accepted      (accepted),
    .current_state (current_state)
  );

endmodule

// File: rtl/dwr_ram.sv
`timescale 1ns / 1ps

module dwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dwr_ctrl.sv
`timescale 1ns / 1ps

module dwr_ctrl import dwr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dwr_stat_t stat,
  output dwr_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // commands
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_FIN) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.need_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/dwr_dp.sv
`timescale 1ns / 1ps

module dwr_dp import dwr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] opcode,
  input  logic [7:0] state_a,
  input  logic [7:0] symbol,
  input  logic [7:0] state_b,
  input  dwr_cmd_t   cmd,
  output dwr_stat_t  stat,
  output logic [1:0] status,
  output logic       word_done,
  output logic       accepted,
  output logic [7:0] current_state
);

  // item registers
  logic [2:0]  item_op;
  state_t      item_sa;
  logic [7:0]  item_sym;
  state_t      item_sb;

  // automaton state
  logic [EDGE_CW-1:0]     edge_count;
  logic [STATE_COUNT-1:0] accept_map;
  state_t                 start_state;
  logic                   has_start;
  state_t                 current;
  logic                   in_word;
  logic                   rejected;

  // scan state
  logic [EDGE_CW-1:0] idx;
  logic               pv;
  logic               pl;
  logic               found;
  state_t             found_tgt;

  logic        rej_w;
  state_t      cur_w;
  logic        issue;
  logic        match;
  state_t      key_src;
  edge_t       rd_edge;
  edge_t       wr_edge;
  logic [$bits(edge_t)-1:0] rd_data;
  logic        ram_we;
  state_t      acc_addr;
  logic        acc_bit;
  logic        table_full;

  // result word before the output register
  logic [1:0]  status_next;
  logic        word_done_next;
  logic        accepted_next;
  logic [7:0]  current_state_next;

  // word start view of state
  assign rej_w = in_word ? rejected : !has_start;
  assign cur_w = (!in_word && has_start) ? start_state : current;

  assign stat.need_scan = (edge_count != '0) &&
                          ((opcode == OP_ADD_EDGE) ||
                           ((opcode == OP_SYMBOL) && (symbol != 8'd0) && !rej_w));

  // edge table
  assign issue      = cmd.scan && (idx < edge_count);
  assign table_full = (edge_count == EDGE_CW'(MAX_EDGES));
  assign ram_we     = cmd.commit && (item_op == OP_ADD_EDGE) && !found && !table_full;
  assign wr_edge    = '{src: item_sa, lab: item_sym, tgt: item_sb};

  dwr_ram #(
    .WIDTH ($bits(edge_t)),
    .DEPTH (MAX_EDGES)
  ) u_edges (
    .clk   (clk),
    .we    (ram_we),
    .waddr (edge_count[EDGE_AW-1:0]),
    .wdata (wr_edge),
    .re    (issue),
    .raddr (idx[EDGE_AW-1:0]),
    .rdata (rd_data)
  );

  // compare the entry read last cycle
  assign rd_edge = edge_t'(rd_data);
  assign key_src = (item_op == OP_ADD_EDGE) ? item_sa : cur_w;
  assign match   = (rd_edge.src == key_src) && (rd_edge.lab == item_sym) &&
                   ((item_op != OP_ADD_EDGE) || (rd_edge.tgt == item_sb));
  assign stat.scan_done = pv && (match || pl);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op  <= opcode;
      item_sa  <= state_t'(state_a);
      item_sym <= symbol;
      item_sb  <= state_t'(state_b);
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      pv    <= 1'b0;
      pl    <= 1'b0;
      found <= 1'b0;
    end else if (cmd.load) begin
      idx   <= '0;
      pv    <= 1'b0;
      pl    <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      pv <= issue;
      pl <= (idx + EDGE_CW'(1)) == edge_count;
      if (issue) begin
        idx <= idx + EDGE_CW'(1);
      end
      if (pv && match && !found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && pv && match && !found) begin
      found_tgt <= rd_edge.tgt;
    end
  end

  // accept map lookup
  assign acc_addr = (item_op == OP_ADD_ACCEPT) ? item_sa : cur_w;
  assign acc_bit  = accept_map[acc_addr];

  // commit and result
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count  <= '0;
      accept_map  <= '0;
      start_state <= '0;
      has_start   <= 1'b0;
      current     <= '0;
      in_word     <= 1'b0;
      rejected    <= 1'b0;
    end else if (cmd.commit) begin
      case (item_op)
        OP_ADD_EDGE: begin
          if (ram_we) begin
            edge_count <= edge_count + EDGE_CW'(1);
          end
        end
        OP_ADD_ENTRY: begin
          if (!has_start) begin
            start_state <= item_sa;
            has_start   <= 1'b1;
          end
        end
        OP_ADD_ACCEPT: begin
          accept_map[acc_addr] <= 1'b1;
        end
        OP_SYMBOL, OP_END: begin
          if ((item_op == OP_SYMBOL) && (item_sym != 8'd0)) begin
            in_word  <= 1'b1;
            rejected <= rej_w || !found;
            current  <= (!rej_w && found) ? found_tgt : cur_w;
          end else begin
            in_word  <= 1'b0;
            rejected <= 1'b0;
            current  <= cur_w;
          end
        end
        default: ;
      endcase
    end
  end

  // result word fields
  always_comb begin
    status_next        = ST_OK;
    word_done_next     = 1'b0;
    accepted_next      = 1'b0;
    current_state_next = 8'(current);
    case (item_op)
      OP_ADD_EDGE: begin
        if (found) begin
          status_next = ST_DUP;
        end else if (table_full) begin
          status_next = ST_FULL;
        end
      end
      OP_ADD_ENTRY: begin
        if (has_start) begin
          status_next = ST_DUP;
        end
      end
      OP_ADD_ACCEPT: begin
        if (acc_bit) begin
          status_next = ST_DUP;
        end
      end
      OP_SYMBOL, OP_END: begin
        status_next = has_start ? ST_OK : ST_NO_ENTRY;
        if ((item_op == OP_SYMBOL) && (item_sym != 8'd0)) begin
          current_state_next = 8'((!rej_w && found) ? found_tgt : cur_w);
        end else begin
          word_done_next     = 1'b1;
          accepted_next      = !rej_w && acc_bit;
          current_state_next = 8'(cur_w);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= status_next;
      word_done     <= word_done_next;
      accepted      <= accepted_next;
      current_state <= current_state_next;
    end
  end

endmodule
